### rtl/tlsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlsr_pkg;

   // Boxcar averaging depth and the widths that follow from it.
   localparam int AvgDepth = 10;
   localparam int PosW = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;
   localparam int TotW = 16 + $clog2(AvgDepth);
   // Reciprocal for the divide by AvgDepth: floor(mag * RecipMul >> RecipShift)
   // equals floor(mag / AvgDepth) for every TotW-bit magnitude.
   localparam int RecipShift = TotW + $clog2(AvgDepth);
   localparam logic [RecipShift:0] RecipMul =
      (RecipShift + 1)'(((64'd1 << RecipShift) + 64'(AvgDepth) - 64'd1) / 64'(AvgDepth));
   localparam int ProdW = TotW + RecipShift + 1;

   localparam logic [16:0] ElapsedMax = 17'h1FFFF;

   // Configuration register indexes.
   localparam logic [2:0] RegEnableThr   = 3'd0;
   localparam logic [2:0] RegKillThr     = 3'd1;
   localparam logic [2:0] RegMinSolar    = 3'd2;
   localparam logic [2:0] RegLoad1Boot   = 3'd3;
   localparam logic [2:0] RegLoad2Boot   = 3'd4;
   localparam logic [2:0] RegSettle      = 3'd5;
   localparam logic [2:0] RegActuate     = 3'd6;
   localparam logic [2:0] RegInitPeriod  = 3'd7;

   // Load command codes.
   localparam logic [1:0] CmdNone   = 2'd0;
   localparam logic [1:0] CmdEngage = 2'd1;
   localparam logic [1:0] CmdKill   = 2'd2;

   // Control state codes as seen on the result.
   localparam logic [3:0] CodeDefault = 4'd0;
   localparam logic [3:0] CodeKillAll = 4'd1;
   localparam logic [3:0] CodeOffOff  = 4'd2;
   localparam logic [3:0] CodeEngage1 = 4'd3;
   localparam logic [3:0] CodeOnOff   = 4'd4;
   localparam logic [3:0] CodeEngage2 = 4'd5;
   localparam logic [3:0] CodeOnOn    = 4'd6;
   localparam logic [3:0] CodeKill1   = 4'd7;
   localparam logic [3:0] CodeKill2   = 4'd8;

   typedef enum logic [7:0] {
      ST_KILL_ALL = 8'b0000_0001,
      ST_OFF_OFF  = 8'b0000_0010,
      ST_ENGAGE1  = 8'b0000_0100,
      ST_ON_OFF   = 8'b0000_1000,
      ST_ENGAGE2  = 8'b0001_0000,
      ST_ON_ON    = 8'b0010_0000,
      ST_KILL1    = 8'b0100_0000,
      ST_KILL2    = 8'b1000_0000
   } ctrl_state_type;

   typedef struct packed {
      logic signed [15:0] enable_thr;
      logic signed [15:0] kill_thr;
      logic [14:0]        min_solar;
      logic [15:0]        load1_boot;
      logic [15:0]        load2_boot;
      logic [15:0]        settle;
      logic [15:0]        actuate;
      logic [15:0]        initial_period;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  state_code;
      logic [1:0]  load1_cmd;
      logic [1:0]  load2_cmd;
      logic        event_flag;
      logic [14:0] shed_solar;
      logic [15:0] load1_engages;
      logic [15:0] load1_disengages;
      logic [15:0] load2_engages;
      logic [15:0] load2_disengages;
   } ctrl_status_type;

   function automatic logic [3:0] state_code(input ctrl_state_type st);
      logic [3:0] code;
      case (st)
         ST_KILL_ALL: code = CodeKillAll;
         ST_OFF_OFF:  code = CodeOffOff;
         ST_ENGAGE1:  code = CodeEngage1;
         ST_ON_OFF:   code = CodeOnOff;
         ST_ENGAGE2:  code = CodeEngage2;
         ST_ON_ON:    code = CodeOnOn;
         ST_KILL1:    code = CodeKill1;
         ST_KILL2:    code = CodeKill2;
         default:     code = CodeDefault;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

### rtl/tlsr_avg.sv
`timescale 1ns / 1ps
`default_nettype none

module tlsr_avg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               sample_accept,
   input  wire logic signed [15:0] import_watts,
   input  wire logic [14:0]        solar_watts,
   output logic signed [15:0]      average,
   output logic [14:0]             last_solar,
   output logic [14:0]             peak_solar
);
   import tlsr_pkg::*;

   logic signed [15:0]     ring_ff [AvgDepth];
   logic [PosW-1:0]        pos_ff, pos_in;
   logic signed [TotW-1:0] total_ff, total_in;
   logic signed [15:0]     avg_ff, avg_in;
   logic [14:0]            solar_ff;
   logic [14:0]            peak_ff, peak_in;

   logic [TotW-1:0]  mag;
   logic [ProdW-1:0] prod;
   logic [15:0]      quot;

   // Replace the oldest sample and update the running total.
   assign total_in = total_ff - TotW'(ring_ff[pos_ff]) + TotW'(import_watts);
   assign pos_in   = (pos_ff == PosW'(AvgDepth - 1)) ? '0 : pos_ff + 1'b1;

   // Divide by the depth through a reciprocal multiply on the magnitude, so the
   // quotient truncates toward zero.
   assign mag    = total_in[TotW-1] ? TotW'(-total_in) : TotW'(total_in);
   assign prod   = ProdW'(mag) * ProdW'(RecipMul);
   assign quot   = 16'(prod >> RecipShift);
   assign avg_in = total_in[TotW-1] ? -$signed(quot) : $signed(quot);

   assign peak_in = (solar_watts > peak_ff) ? solar_watts : peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AvgDepth; i++) begin
            ring_ff[i] <= '0;
         end
         pos_ff   <= '0;
         total_ff <= '0;
         avg_ff   <= '0;
         solar_ff <= '0;
         peak_ff  <= '0;
      end else if (sample_accept) begin
         ring_ff[pos_ff] <= import_watts;
         pos_ff          <= pos_in;
         total_ff        <= total_in;
         avg_ff          <= avg_in;
         solar_ff        <= solar_watts;
         peak_ff         <= peak_in;
      end
   end

   assign average    = avg_ff;
   assign last_solar = solar_ff;
   assign peak_solar = peak_ff;

endmodule

`default_nettype wire

### rtl/tlsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tlsr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               tick_accept,
   input  wire logic               item_accept,
   input  wire logic signed [15:0] average,
   input  wire logic [14:0]        last_solar,
   input  wire tlsr_pkg::cfg_type  cfg,
   input  wire logic               init_period_wr,
   input  wire logic [15:0]        init_period_value,
   output tlsr_pkg::ctrl_status_type status
);
   import tlsr_pkg::*;

   ctrl_state_type state_ff, state_in, state_dec;
   logic [16:0] decide_el_ff, decide_el_in, decide_inc;
   logic [16:0] act_el_ff, act_el_in, act_inc;
   logic [15:0] period_ff, period_in;
   logic [14:0] shed_ff, shed_in;
   logic [1:0]  cmd1_ff, cmd1_in, cmd2_ff, cmd2_in;
   logic        ev_ff, ev_in;
   logic [15:0] l1e_ff, l1e_in, l1d_ff, l1d_in, l2e_ff, l2e_in, l2d_ff, l2d_in;
   logic        decide_fire, act_fire;

   assign decide_inc  = (decide_el_ff == ElapsedMax) ? decide_el_ff : decide_el_ff + 1'b1;
   assign act_inc     = (act_el_ff == ElapsedMax) ? act_el_ff : act_el_ff + 1'b1;
   assign decide_fire = decide_inc > {1'b0, period_ff};
   assign act_fire    = act_inc > {1'b0, cfg.actuate};

   always_comb begin
      state_dec    = state_ff;
      state_in     = state_ff;
      period_in    = period_ff;
      shed_in      = shed_ff;
      decide_el_in = decide_el_ff;
      act_el_in    = act_el_ff;
      cmd1_in      = CmdNone;
      cmd2_in      = CmdNone;
      ev_in        = 1'b0;
      l1e_in       = l1e_ff;
      l1d_in       = l1d_ff;
      l2e_in       = l2e_ff;
      l2d_in       = l2d_ff;

      if (tick_accept) begin
         decide_el_in = decide_fire ? '0 : decide_inc;
         act_el_in    = act_fire ? '0 : act_inc;

         // Decide step: engage the next load on surplus, shed one on strong export.
         if (decide_fire) begin
            if (average > cfg.enable_thr && last_solar > cfg.min_solar) begin
               period_in = cfg.load1_boot;
               if (state_ff == ST_OFF_OFF) begin
                  state_dec = ST_ENGAGE1;
                  ev_in     = 1'b1;
               end else if (state_ff == ST_ON_OFF) begin
                  state_dec = ST_ENGAGE2;
                  period_in = cfg.load2_boot;
                  ev_in     = 1'b1;
               end
            end else if (average <= cfg.kill_thr) begin
               period_in = cfg.settle;
               if (state_ff == ST_ON_OFF) begin
                  state_dec = ST_KILL1;
                  shed_in   = last_solar;
                  ev_in     = 1'b1;
               end else if (state_ff == ST_ON_ON) begin
                  state_dec = ST_KILL2;
                  shed_in   = last_solar;
                  ev_in     = 1'b1;
               end
            end
         end

         // Actuate step sees the state that the decide step just produced.
         state_in = state_dec;
         if (act_fire) begin
            case (state_dec)
               ST_ENGAGE1: begin
                  cmd1_in  = CmdEngage;
                  state_in = ST_ON_OFF;
                  l1e_in   = (l1e_ff == 16'hFFFF) ? l1e_ff : l1e_ff + 1'b1;
                  ev_in    = 1'b1;
               end
               ST_ENGAGE2: begin
                  cmd2_in  = CmdEngage;
                  state_in = ST_ON_ON;
                  l2e_in   = (l2e_ff == 16'hFFFF) ? l2e_ff : l2e_ff + 1'b1;
                  ev_in    = 1'b1;
               end
               ST_KILL1: begin
                  cmd1_in  = CmdKill;
                  state_in = ST_OFF_OFF;
                  l1d_in   = (l1d_ff == 16'hFFFF) ? l1d_ff : l1d_ff + 1'b1;
                  ev_in    = 1'b1;
               end
               ST_KILL2: begin
                  cmd2_in  = CmdKill;
                  state_in = ST_ON_OFF;
                  l2d_in   = (l2d_ff == 16'hFFFF) ? l2d_ff : l2d_ff + 1'b1;
                  ev_in    = 1'b1;
               end
               ST_KILL_ALL: begin
                  cmd1_in  = CmdKill;
                  cmd2_in  = CmdKill;
                  state_in = ST_OFF_OFF;
                  ev_in    = 1'b1;
               end
               default: begin
                  state_in = state_dec;
               end
            endcase
         end
      end

      // Writing the initial period also reloads the running decision period.
      if (init_period_wr) begin
         period_in = init_period_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KILL_ALL;
         decide_el_ff <= ElapsedMax;
         act_el_ff    <= ElapsedMax;
         period_ff    <= 16'd5;
         shed_ff      <= '0;
         cmd1_ff      <= CmdNone;
         cmd2_ff      <= CmdNone;
         ev_ff        <= 1'b0;
         l1e_ff       <= '0;
         l1d_ff       <= '0;
         l2e_ff       <= '0;
         l2d_ff       <= '0;
      end else begin
         period_ff <= period_in;
         if (item_accept) begin
            state_ff     <= state_in;
            decide_el_ff <= decide_el_in;
            act_el_ff    <= act_el_in;
            shed_ff      <= shed_in;
            cmd1_ff      <= cmd1_in;
            cmd2_ff      <= cmd2_in;
            ev_ff        <= ev_in;
            l1e_ff       <= l1e_in;
            l1d_ff       <= l1d_in;
            l2e_ff       <= l2e_in;
            l2d_ff       <= l2d_in;
         end
      end
   end

   assign status.state_code       = state_code(state_ff);
   assign status.load1_cmd        = cmd1_ff;
   assign status.load2_cmd        = cmd2_ff;
   assign status.event_flag       = ev_ff;
   assign status.shed_solar       = shed_ff;
   assign status.load1_engages    = l1e_ff;
   assign status.load1_disengages = l1d_ff;
   assign status.load2_engages    = l2e_ff;
   assign status.load2_disengages = l2d_ff;

`ifndef SYNTH
   // A command always comes with the event flag.
   a_cmd_event: assert property (@(posedge clock) disable iff (reset)
      (cmd1_ff != CmdNone || cmd2_ff != CmdNone) |-> ev_ff)
      else $error("load command without event flag");

   // Killing both loads at once only happens on the way to off/off.
   a_kill_all: assert property (@(posedge clock) disable iff (reset)
      (cmd1_ff == CmdKill && cmd2_ff == CmdKill) |-> state_ff == ST_OFF_OFF)
      else $error("double kill did not land in off/off");

   // A power sample never produces an event.
   a_sample_quiet: assert property (@(posedge clock) disable iff (reset)
      (item_accept && !tick_accept) |=> !ev_ff)
      else $error("event flag set on a power sample");

   // The control state moves only when an item is taken.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !item_accept |=> $stable(state_ff))
      else $error("control state changed without an item");
`endif

endmodule

`default_nettype wire

### rtl/two_load_surplus_regulator_core.sv
// A result appears on rsp in the cycle after its item transfer on req.
// Throughput: one item per cycle while rsp is not stalled; a sample or a tick is fully processed in a
// single pass, so the next transfer is taken while the previous result leaves.
// Reset (synchronous, active high) loads the register defaults, clears the
// averaging ring and counters, enters the kill-all state and primes both timers
// so that the first tick fires them.
`timescale 1ns / 1ps
`default_nettype none

module two_load_surplus_regulator_core (
   input  wire logic         clock,
   input  wire logic         reset,
   // Item input channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // [15:0] import_watts, [30:16] solar_watts, [31] zero
   input  wire logic         req_tuser,   // [0] mode: 0 power sample, 1 one-second tick
   // Result channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [119:0]      rsp_tdata,   // [15:0] avg_import, [19:16] control_state,
                                          // [21:20] load1_command, [23:22] load2_command,
                                          // [24] event_flag, [39:25] peak_solar,
                                          // [54:40] solar_at_shed, [70:55] load1_engages,
                                          // [86:71] load1_disengages, [102:87] load2_engages,
                                          // [118:103] load2_disengages, [119] zero
   // Configuration write channel.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_data
);
   import tlsr_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            item_accept, sample_accept, tick_accept;
   logic            csr_write, init_period_wr;
   logic signed [15:0] average;
   logic [14:0]     last_solar, peak_solar;
   ctrl_status_type status;

   // The result registers live in the two submodules and hold still while a
   // result waits, so a new transfer is taken whenever the output slot is free
   // or is being emptied in the same cycle.
   assign req_tready    = !rsp_valid_ff || rsp_tready;
   assign item_accept   = req_tvalid && req_tready;
   assign sample_accept = item_accept && !req_tuser;
   assign tick_accept   = item_accept && req_tuser;
   assign rsp_valid_in  = item_accept || (rsp_valid_ff && !rsp_tready);

   // Configuration writes are always taken; the user must issue them only while idle.
   assign csr_ready      = 1'b1;
   assign csr_write      = csr_valid && csr_ready;
   assign init_period_wr = csr_write && (csr_index == RegInitPeriod);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            RegEnableThr:  cfg_in.enable_thr     = $signed(csr_data);
            RegKillThr:    cfg_in.kill_thr       = $signed(csr_data);
            RegMinSolar:   cfg_in.min_solar      = csr_data[14:0];
            RegLoad1Boot:  cfg_in.load1_boot     = csr_data;
            RegLoad2Boot:  cfg_in.load2_boot     = csr_data;
            RegSettle:     cfg_in.settle         = csr_data;
            RegActuate:    cfg_in.actuate        = csr_data;
            RegInitPeriod: cfg_in.initial_period = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff          <= 1'b0;
         cfg_ff.enable_thr     <= -16'sd90;
         cfg_ff.kill_thr       <= -16'sd1000;
         cfg_ff.min_solar      <= '0;
         cfg_ff.load1_boot     <= 16'd60;
         cfg_ff.load2_boot     <= 16'd60;
         cfg_ff.settle         <= 16'd60;
         cfg_ff.actuate        <= 16'd10;
         cfg_ff.initial_period <= 16'd5;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Sample path: ring buffer, boxcar average and solar tracking.
   tlsr_avg u_avg (
      .clock         (clock),
      .reset         (reset),
      .sample_accept (sample_accept),
      .import_watts  ($signed(req_tdata[15:0])),
      .solar_watts   (req_tdata[30:16]),
      .average       (average),
      .last_solar    (last_solar),
      .peak_solar    (peak_solar)
   );

   // Tick path: decide and actuate timers, load state and command counters.
   // A write of the initial period hands the new value straight to the
   // running decision period, in the same cycle as the register write.
   tlsr_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .tick_accept       (tick_accept),
      .item_accept       (item_accept),
      .average           (average),
      .last_solar        (last_solar),
      .cfg               (cfg_ff),
      .init_period_wr    (init_period_wr),
      .init_period_value (csr_data),
      .status            (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        status.load2_disengages,
                        status.load2_engages,
                        status.load1_disengages,
                        status.load1_engages,
                        status.shed_solar,
                        peak_solar,
                        status.event_flag,
                        status.load2_cmd,
                        status.load1_cmd,
                        status.state_code,
                        average};

endmodule

`default_nettype wire

### sim/tlsr_outcome_checker.sv
`timescale 1ns / 1ps

module tlsr_outcome_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [31:0]  req_tdata,   // [15:0] import_watts, [30:16] solar_watts, [31] zero
   input  wire logic         req_tuser,   // [0] mode: 0 power sample, 1 one-second tick
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [119:0] rsp_tdata,   // [15:0] avg_import, [19:16] control_state,
                                          // [21:20] load1_command, [23:22] load2_command,
                                          // [24] event_flag, [39:25] peak_solar,
                                          // [54:40] solar_at_shed, [70:55] load1_engages,
                                          // [86:71] load1_disengages, [102:87] load2_engages,
                                          // [118:103] load2_disengages, [119] zero
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_data,
   output int                mismatches,
   output int                outstanding
);

   import tlsr_pkg::*;

   localparam int RING_DEPTH = 10;
   localparam int L1_ON  = 0;
   localparam int L1_OFF = 1;
   localparam int L2_ON  = 2;
   localparam int L2_OFF = 3;

   typedef struct packed {
      logic signed [15:0] avg_import;
      logic [3:0]         control_state;
      logic [1:0]         load1_command;
      logic [1:0]         load2_command;
      logic               event_flag;
      logic [14:0]        peak_solar;
      logic [14:0]        solar_at_shed;
      logic [15:0]        load1_engages;
      logic [15:0]        load1_disengages;
      logic [15:0]        load2_engages;
      logic [15:0]        load2_disengages;
   } regulator_status_t;

   // Register copies.
   logic signed [15:0] enable_thr;
   logic signed [15:0] kill_thr;
   logic [14:0]        min_solar;
   logic [15:0]        load1_boot;
   logic [15:0]        load2_boot;
   logic [15:0]        settle_period;
   logic [15:0]        actuate_period;
   logic [15:0]        initial_period;

   // Regulator state copy.
   int                 ring_samples [RING_DEPTH];
   int                 ring_slot;
   int                 ring_sum;
   int                 avg_watts;
   logic [14:0]        last_solar;
   logic [14:0]        peak_seen;
   logic [14:0]        shed_latch;
   logic [3:0]         ctrl_code;
   logic [16:0]        decide_elapsed;
   logic [16:0]        actuate_elapsed;
   logic [15:0]        decide_period;
   logic [15:0]        command_counts [4];

   regulator_status_t  awaited_status [$];

   function automatic logic [16:0] step_elapsed(input logic [16:0] seconds);
      return (seconds == 17'h1FFFF) ? seconds : seconds + 17'd1;
   endfunction

   function automatic logic [15:0] count_up(input logic [15:0] count);
      return (count == 16'hFFFF) ? count : count + 16'd1;
   endfunction

   // Advances the regulator copy by one item and returns the status it reports.
   function automatic regulator_status_t regulate_item(input logic is_tick,
                                                       input logic signed [15:0] import_w,
                                                       input logic [14:0] solar_w);
      regulator_status_t status;
      logic [1:0]        cmd1;
      logic [1:0]        cmd2;
      logic              logged;
      cmd1   = CmdNone;
      cmd2   = CmdNone;
      logged = 1'b0;
      if (!is_tick) begin
         ring_sum = ring_sum - ring_samples[ring_slot] + int'(import_w);
         ring_samples[ring_slot] = int'(import_w);
         ring_slot = (ring_slot + 1) % RING_DEPTH;
         // Integer division truncates toward zero, as the block does.
         avg_watts = ring_sum / RING_DEPTH;
         last_solar = solar_w;
         if (solar_w > peak_seen)
            peak_seen = solar_w;
      end else begin
         decide_elapsed = step_elapsed(decide_elapsed);
         if (decide_elapsed > {1'b0, decide_period}) begin
            decide_elapsed = '0;
            if (avg_watts > int'(enable_thr) && last_solar > min_solar) begin
               decide_period = load1_boot;
               if (ctrl_code == CodeOffOff) begin
                  ctrl_code = CodeEngage1;
                  logged = 1'b1;
               end else if (ctrl_code == CodeOnOff) begin
                  ctrl_code = CodeEngage2;
                  decide_period = load2_boot;
                  logged = 1'b1;
               end
            end else if (avg_watts <= int'(kill_thr)) begin
               decide_period = settle_period;
               if (ctrl_code == CodeOnOff) begin
                  ctrl_code = CodeKill1;
                  shed_latch = last_solar;
                  logged = 1'b1;
               end else if (ctrl_code == CodeOnOn) begin
                  ctrl_code = CodeKill2;
                  shed_latch = last_solar;
                  logged = 1'b1;
               end
            end
         end
         // Actuation sees whatever the decision above just set.
         actuate_elapsed = step_elapsed(actuate_elapsed);
         if (actuate_elapsed > {1'b0, actuate_period}) begin
            actuate_elapsed = '0;
            case (ctrl_code)
               CodeEngage1: begin
                  cmd1 = CmdEngage;
                  ctrl_code = CodeOnOff;
                  command_counts[L1_ON] = count_up(command_counts[L1_ON]);
                  logged = 1'b1;
               end
               CodeEngage2: begin
                  cmd2 = CmdEngage;
                  ctrl_code = CodeOnOn;
                  command_counts[L2_ON] = count_up(command_counts[L2_ON]);
                  logged = 1'b1;
               end
               CodeKill1: begin
                  cmd1 = CmdKill;
                  ctrl_code = CodeOffOff;
                  command_counts[L1_OFF] = count_up(command_counts[L1_OFF]);
                  logged = 1'b1;
               end
               CodeKill2: begin
                  cmd2 = CmdKill;
                  ctrl_code = CodeOnOff;
                  command_counts[L2_OFF] = count_up(command_counts[L2_OFF]);
                  logged = 1'b1;
               end
               CodeKillAll: begin
                  cmd1 = CmdKill;
                  cmd2 = CmdKill;
                  ctrl_code = CodeOffOff;
                  logged = 1'b1;
               end
               default: ;
            endcase
         end
      end
      status.avg_import       = 16'(avg_watts);
      status.control_state    = ctrl_code;
      status.load1_command    = cmd1;
      status.load2_command    = cmd2;
      status.event_flag       = logged;
      status.peak_solar       = peak_seen;
      status.solar_at_shed    = shed_latch;
      status.load1_engages    = command_counts[L1_ON];
      status.load1_disengages = command_counts[L1_OFF];
      status.load2_engages    = command_counts[L2_ON];
      status.load2_disengages = command_counts[L2_OFF];
      return status;
   endfunction

   function automatic void compare_field(input string field_name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 'h%0h, got 'h%0h", $time, field_name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      regulator_status_t want;
      regulator_status_t got;
      if (reset) begin
         enable_thr      = -16'sd90;
         kill_thr        = -16'sd1000;
         min_solar       = '0;
         load1_boot      = 16'd60;
         load2_boot      = 16'd60;
         settle_period   = 16'd60;
         actuate_period  = 16'd10;
         initial_period  = 16'd5;
         for (int i = 0; i < RING_DEPTH; i++)
            ring_samples[i] = 0;
         ring_slot       = 0;
         ring_sum        = 0;
         avg_watts       = 0;
         last_solar      = '0;
         peak_seen       = '0;
         shed_latch      = '0;
         ctrl_code       = CodeKillAll;
         decide_elapsed  = 17'h1FFFF;
         actuate_elapsed = 17'h1FFFF;
         decide_period   = 16'd5;
         for (int i = 0; i < 4; i++)
            command_counts[i] = '0;
         awaited_status.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = regulator_status_t'(rsp_tdata[118:0]);
            got.avg_import       = rsp_tdata[15:0];
            got.control_state    = rsp_tdata[19:16];
            got.load1_command    = rsp_tdata[21:20];
            got.load2_command    = rsp_tdata[23:22];
            got.event_flag       = rsp_tdata[24];
            got.peak_solar       = rsp_tdata[39:25];
            got.solar_at_shed    = rsp_tdata[54:40];
            got.load1_engages    = rsp_tdata[70:55];
            got.load1_disengages = rsp_tdata[86:71];
            got.load2_engages    = rsp_tdata[102:87];
            got.load2_disengages = rsp_tdata[118:103];
            if (awaited_status.size() == 0) begin
               $display("%0t: result transfer with none expected, got 'h%0h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_status.pop_front();
               compare_field("avg_import", want.avg_import, got.avg_import);
               compare_field("control_state", 16'(want.control_state),
                             16'(got.control_state));
               compare_field("load1_command", 16'(want.load1_command),
                             16'(got.load1_command));
               compare_field("load2_command", 16'(want.load2_command),
                             16'(got.load2_command));
               compare_field("event_flag", 16'(want.event_flag), 16'(got.event_flag));
               compare_field("peak_solar", 16'(want.peak_solar), 16'(got.peak_solar));
               compare_field("solar_at_shed", 16'(want.solar_at_shed),
                             16'(got.solar_at_shed));
               compare_field("load1_engages", want.load1_engages, got.load1_engages);
               compare_field("load1_disengages", want.load1_disengages,
                             got.load1_disengages);
               compare_field("load2_engages", want.load2_engages, got.load2_engages);
               compare_field("load2_disengages", want.load2_disengages,
                             got.load2_disengages);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegEnableThr:  enable_thr = csr_data;
               RegKillThr:    kill_thr = csr_data;
               RegMinSolar:   min_solar = csr_data[14:0];
               RegLoad1Boot:  load1_boot = csr_data;
               RegLoad2Boot:  load2_boot = csr_data;
               RegSettle:     settle_period = csr_data;
               RegActuate:    actuate_period = csr_data;
               RegInitPeriod: begin
                  initial_period = csr_data;
                  decide_period  = csr_data;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            awaited_status.push_back(regulate_item(req_tuser, req_tdata[15:0],
                                                   req_tdata[30:16]));
      end
      outstanding = awaited_status.size();
   end

endmodule

### sim/two_load_surplus_regulator_core_tb.sv
`timescale 1ns / 1ps

module two_load_surplus_regulator_core_tb;

   import tlsr_pkg::*;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata  = '0;   // [15:0] import_watts, [30:16] solar_watts, [31] zero
   logic         req_tuser  = 1'b0; // [0] mode: 0 power sample, 1 one-second tick
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;         // [15:0] avg_import, [19:16] control_state,
                                    // [21:20] load1_command, [23:22] load2_command,
                                    // [24] event_flag, [39:25] peak_solar,
                                    // [54:40] solar_at_shed, [70:55] load1_engages,
                                    // [86:71] load1_disengages, [102:87] load2_engages,
                                    // [118:103] load2_disengages, [119] zero
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index  = '0;
   logic [15:0]  csr_data   = '0;

   int           failures;
   int           pending_results;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int           send_idle_pct  = 15;
   int           recv_stall_pct = 82;

   // The clock runs with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   two_load_surplus_regulator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // The checker watches all three channels, predicts every result and counts
   // mismatches. It also reports how many results are still owed.
   tlsr_outcome_checker u_outcome_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (failures),
      .outstanding (pending_results)
   );

   // The receiver decides afresh at every falling edge whether to take a result.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // Offers one item and returns at the falling edge after its transfer. The
   // valid is left high so that back-to-back items keep it asserted; callers
   // lower it once a batch is done.
   task automatic send_item(input logic is_tick, input logic [15:0] import_w,
                            input logic [14:0] solar_w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_tick;
      req_tdata  <= {1'b0, solar_w, import_w};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // One register write. The extra falling edge at the end keeps the lowering
   // of the valid and the next write's raise in different time steps.
   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [15:0] enable_thr, input logic [15:0] kill_thr,
                               input logic [15:0] min_solar, input logic [15:0] load1_boot,
                               input logic [15:0] load2_boot, input logic [15:0] settle,
                               input logic [15:0] actuate, input logic [15:0] init_period);
      write_reg(RegEnableThr, enable_thr);
      write_reg(RegKillThr, kill_thr);
      write_reg(RegMinSolar, min_solar);
      write_reg(RegLoad1Boot, load1_boot);
      write_reg(RegLoad2Boot, load2_boot);
      write_reg(RegSettle, settle);
      write_reg(RegActuate, actuate);
      write_reg(RegInitPeriod, init_period);
   endtask

   // Thresholds around the usual operating range and short periods, so that
   // the controller keeps moving through its states.
   task automatic program_random_regs;
      program_regs(16'(int'($urandom_range(0, 4000)) - 3000),
                   16'(-int'($urandom_range(500, 6000))),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 2)), 16'($urandom_range(0, 3)));
   endtask

   // Lowers the item valid and waits until every owed result has left. Each
   // item yields exactly one result, so the block is idle afterwards.
   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
   endtask

   // Random traffic in bursts. A burst is biased toward surplus (engaging
   // loads), toward heavy export (shedding loads), toward pure noise, or is
   // a run of ticks that lets the timers fire repeatedly.
   task automatic run_traffic(input int count);
      int          sent;
      int          regime;
      int          burst;
      logic        is_tick;
      logic [15:0] import_w;
      logic [14:0] solar_w;
      sent = 0;
      while (sent < count) begin
         regime = $urandom_range(0, 9);
         burst  = $urandom_range(3, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            is_tick = (regime == 9) || ($urandom_range(0, 99) < 35);
            if (regime <= 3) begin
               import_w = 16'($urandom_range(0, 32767));
               solar_w  = 15'($urandom_range(0, 32767));
            end else if (regime <= 6) begin
               import_w = 16'(-int'($urandom_range(1000, 32768)));
               solar_w  = 15'($urandom_range(0, 32767));
            end else begin
               import_w = 16'($urandom());
               solar_w  = 15'($urandom());
            end
            if ($urandom_range(0, 19) == 0)
               import_w = (regime <= 3) ? 16'h7FFF : 16'h8000;
            send_item(is_tick, import_w, solar_w);
            sent++;
         end
      end
   endtask

   // Cycles both loads through every command. Engaging is allowed for any
   // average and shedding happens whenever engaging is refused, so the solar
   // reading of the last sample alone picks the direction. One round engages
   // both loads, then sheds both, one command per tick.
   task automatic saturate_counters(input int rounds);
      for (int k = 0; k < 10; k++)
         send_item(1'b0, 16'(int'($urandom_range(0, 65534)) - 32767), 15'd0);
      repeat (3)
         send_item(1'b1, 16'($urandom()), 15'($urandom()));
      for (int r = 0; r < rounds; r++) begin
         send_item(1'b0, 16'(int'($urandom_range(0, 65534)) - 32767),
                   15'($urandom_range(1, 32767)));
         send_item(1'b1, 16'($urandom()), 15'($urandom()));
         send_item(1'b1, 16'($urandom()), 15'($urandom()));
         send_item(1'b0, 16'(int'($urandom_range(0, 65534)) - 32767), 15'd0);
         send_item(1'b1, 16'($urandom()), 15'($urandom()));
         send_item(1'b1, 16'($urandom()), 15'($urandom()));
      end
   endtask

   initial begin
      repeat (12)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: the first tick fires both timers. There is no solar
      // yet, so the decision sees neither condition, and actuation kills both
      // loads from the kill-all state without touching the counters.
      send_item(1'b1, 16'h0000, 15'h0000);
      send_item(1'b0, 16'h7FFF, 15'h7FFF);
      send_item(1'b0, 16'h8000, 15'h0000);
      send_item(1'b1, 16'hFFFF, 15'h7FFF);
      drain_results();

      // Zero periods make every tick fire both steps, except while the second load's boot period runs.
      program_regs(16'd0, -16'd1000, 16'd100, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
      // Surplus, but the solar reading is not above the minimum: no decision.
      send_item(1'b0, 16'h7FFF, 15'd200);
      send_item(1'b0, 16'h7FFF, 15'd50);
      send_item(1'b1, 16'h0000, 15'h0000);
      // With enough solar the first load, then the second, are engaged.
      send_item(1'b0, 16'd1000, 15'h7FFF);
      send_item(1'b1, 16'h0000, 15'h0000);
      send_item(1'b1, 16'h0000, 15'h0000);
      // The second load's boot period holds the decision back for one tick;
      // actuation then has nothing to send. Afterwards surplus is decided with
      // both loads already on, which only resets the period.
      send_item(1'b1, 16'h0000, 15'h0000);
      send_item(1'b1, 16'h0000, 15'h0000);
      // Ten samples at full export pull the average down to its floor.
      repeat (10)
         send_item(1'b0, 16'h8000, 15'd1234);
      // Shed the second load, then the first, then find nothing left to shed.
      send_item(1'b1, 16'h0000, 15'h0000);
      send_item(1'b1, 16'h0000, 15'h0000);
      send_item(1'b1, 16'h0000, 15'h0000);
      drain_results();

      // Phase one: the receiver stalls most of the time.
      program_regs(-16'd90, -16'd1000, 16'd0, 16'd1, 16'd2, 16'd0, 16'd1, 16'd3);
      run_traffic(230);
      drain_results();
      // Extreme settings: engaging can never happen, shedding only at full
      // export, and the long periods keep both timers quiet.
      program_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF);
      run_traffic(40);
      drain_results();

      // Phase two: the sender is the slow side now.
      send_idle_pct  = 82;
      recv_stall_pct = 15;
      program_regs(16'h8000, 16'h7FFF, 16'd16384, 16'd0, 16'd0, 16'd2, 16'd0, 16'd0);
      run_traffic(180);
      drain_results();
      program_random_regs();
      run_traffic(150);
      drain_results();

      // Phase three: both sides run at full rate.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      program_random_regs();
      run_traffic(290);
      drain_results();
      program_regs(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      saturate_counters(5);
      drain_results();

      // The block answers in the cycle after each transfer; the extra falling edges
      // below catch any result that should not be there.
      repeat (4)
         @(negedge clock);
      if (failures == 0 && pending_results == 0)
         $display("two_load_surplus_regulator_core_tb OK");
      else
         $display("two_load_surplus_regulator_core_tb NOT OK");
      $finish;
   end

   // A correct run takes well under a tenth of a millisecond of simulated time;
   // this is far beyond it.
   initial begin
      #2_000_000;
      $display("two_load_surplus_regulator_core_tb NOT OK");
      $finish;
   end

endmodule
